// ===== hdl/clpc_pkg.sv =====
// clpc_pkg: shared types and constants for the character lcd parallel controller
// no dependencies; used by the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package clpc_pkg;

  // sequence timing in microsecond ticks
  localparam int unsigned POWERUP_WAIT_US = 15000;
  localparam int unsigned RETRY_WAIT_US   = 5000;
  localparam int unsigned LINE_COLUMNS    = 16;

  localparam int unsigned CNT_W  = 14;
  localparam int unsigned TIME_W = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // display command bytes
  localparam logic [7:0] CMD_ROW0_ADDR = 8'h80;
  localparam logic [7:0] CMD_ROW1_ADDR = 8'hC0;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0D;

  // reset values of the timing registers
  localparam logic [TIME_W-1:0] SETUP_RST  = 10'd100;
  localparam logic [TIME_W-1:0] PULSE_RST  = 10'd400;
  localparam logic [TIME_W-1:0] HOLD_RST   = 10'd400;
  localparam logic [TIME_W-1:0] SAMPLE_RST = 10'd100;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WRITE_CHR = 2'd1,
    OP_SET_CUR   = 2'd2,
    OP_INIT      = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_BUSY = 3'd0,
    CFG_SETUP     = 3'd1,
    CFG_PULSE     = 3'd2,
    CFG_HOLD      = 3'd3,
    CFG_SAMPLE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_BUSY_HI = 3'd2,
    PH_BUSY_LO = 3'd3,
    PH_SETUP   = 3'd4,
    PH_PULSE   = 3'd5,
    PH_HOLD    = 3'd6
  } phase_e;

  // one result word
  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable_pin;
    logic [7:0] bus_value;
    logic       bus_drive;
    logic       ready_res;
    logic       request_rejected;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/clpc_if.sv =====
// clpc_if: request and result channel interfaces with valid/ready handshake
// depends on nothing; the top level and the testbench use them
`timescale 1ns / 1ps
`default_nettype none

interface clpc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] row;
  logic [4:0] column;
  logic [7:0] character;
  logic       busy_line;

  modport source (output valid, opcode, row, column, character, busy_line, input ready);
  modport sink (input valid, opcode, row, column, character, busy_line, output ready);
endinterface

interface clpc_res_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       read_write;
  logic       enable_pin;
  logic [7:0] bus_value;
  logic       bus_drive;
  logic       ready_res;
  logic       request_rejected;

  modport source (output valid, reg_select, read_write, enable_pin, bus_value, bus_drive,
                  ready_res, request_rejected, input ready);
  modport sink (input valid, reg_select, read_write, enable_pin, bus_value, bus_drive,
                ready_res, request_rejected, output ready);
endinterface

`default_nettype wire

// ===== hdl/char_lcd_parallel_controller_unit.sv =====
// char_lcd_parallel_controller_unit: 8-bit character lcd bus sequencer, needs clpc_pkg and clpc_if
// an accepted word's result is registered into the output stage unless an older one waits
// throughput: one word per cycle while the skid stage is empty; a two-entry output buffer
//   keeps accepting one more word while a result waits, then ready drops until the skid drains
// reset: asynchronous, active low; sequencer idle and uninitialised, pins low,
//   bus driven zero, timing registers at their defaults
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_parallel_controller_unit
  import clpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TIME_W-1:0]    cfg_data_i,
  clpc_req_if.sink                  req_i,
  clpc_res_if.source                res_o
);

  localparam int unsigned COL_CMP_W = 6;

  // configuration registers
  logic              poll_busy_q;
  logic [TIME_W-1:0] setup_q, pulse_q, hold_q, sample_q;

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]      step_q, step_d;
  logic [7:0]      pcmd_q, pcmd_d;
  logic [7:0]      pchr_q, pchr_d;
  logic            follows_q, follows_d;
  logic            inited_q, inited_d;
  logic            sending_q, sending_d;
  logic            rs_q, rs_d, rw_q, rw_d, en_q, en_d, drive_q, drive_d;
  logic [7:0]      bus_q, bus_d;

  // output buffer
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q, res_new;

  logic req_fire, res_fire;
  logic [CNT_W-1:0] cnt_inc, wait_lim;
  logic do_adv, do_init, do_start, start_poll, do_setup, rejected;
  opcode_e op;

  assign op       = opcode_e'(req_i.opcode);
  assign req_fire = req_i.valid && req_i.ready;
  assign res_fire = res_o.valid && res_o.ready;
  assign req_i.ready = !skid_vld_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_busy_q <= 1'b0;
      setup_q     <= SETUP_RST;
      pulse_q     <= PULSE_RST;
      hold_q      <= HOLD_RST;
      sample_q    <= SAMPLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POLL_BUSY: poll_busy_q <= cfg_data_i[0];
        CFG_SETUP:     setup_q     <= cfg_data_i;
        CFG_PULSE:     pulse_q     <= cfg_data_i;
        CFG_HOLD:      hold_q      <= cfg_data_i;
        CFG_SAMPLE:    sample_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign wait_lim = (step_q == 4'd0) ? CNT_W'(POWERUP_WAIT_US) : CNT_W'(RETRY_WAIT_US);

  // next state and result word for one accepted item
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    pcmd_d    = pcmd_q;
    pchr_d    = pchr_q;
    follows_d = follows_q;
    inited_d  = inited_q;
    sending_d = sending_q;
    rs_d      = rs_q;
    rw_d      = rw_q;
    en_d      = en_q;
    drive_d   = drive_q;
    bus_d     = bus_q;
    do_adv     = 1'b0;
    do_init    = 1'b0;
    do_start   = 1'b0;
    start_poll = 1'b0;
    do_setup   = 1'b0;
    rejected   = 1'b0;

    // tick or request
    if (op == OP_TICK) begin
      cnt_d = cnt_inc;
      case (phase_q)
        PH_WAIT: begin
          if (cnt_inc >= wait_lim) do_adv = 1'b1;
        end
        PH_BUSY_HI: begin
          if (cnt_inc >= CNT_W'(sample_q)) begin
            en_d = 1'b0;
            if (req_i.busy_line) phase_d = PH_BUSY_LO;
            else do_setup = 1'b1;
          end
        end
        PH_BUSY_LO: begin
          en_d    = 1'b1;
          phase_d = PH_BUSY_HI;
          cnt_d   = '0;
        end
        PH_SETUP: begin
          if (cnt_inc >= CNT_W'(setup_q)) begin
            en_d    = 1'b1;
            phase_d = PH_PULSE;
            cnt_d   = '0;
          end
        end
        PH_PULSE: begin
          if (cnt_inc >= CNT_W'(pulse_q)) begin
            en_d    = 1'b0;
            phase_d = PH_HOLD;
            cnt_d   = '0;
          end
        end
        PH_HOLD: begin
          if (cnt_inc >= CNT_W'(hold_q)) do_adv = 1'b1;
        end
        default: cnt_d = '0;
      endcase
    end else if (phase_q != PH_IDLE) begin
      rejected = 1'b1;
    end else if (op == OP_INIT) begin
      inited_d  = 1'b0;
      follows_d = 1'b0;
      sending_d = 1'b0;
      step_d    = 4'd0;
      rs_d      = 1'b0;
      rw_d      = 1'b0;
      en_d      = 1'b0;
      bus_d     = 8'h00;
      drive_d   = 1'b1;
      do_init   = 1'b1;
    end else if (!inited_q || req_i.row > 2'd1 ||
                 {1'b0, req_i.column} >= COL_CMP_W'(LINE_COLUMNS)) begin
      rejected = 1'b1;
    end else begin
      pcmd_d     = (req_i.row == 2'd0 ? CMD_ROW0_ADDR : CMD_ROW1_ADDR) +
                   {3'b000, req_i.column};
      pchr_d     = req_i.character;
      follows_d  = (op == OP_WRITE_CHR);
      sending_d  = 1'b0;
      do_start   = 1'b1;
      start_poll = poll_busy_q;
    end

    // end of a wait or a write
    if (do_adv) begin
      if (!inited_q) begin
        step_d  = step_q + 4'd1;
        do_init = 1'b1;
      end else if (follows_q) begin
        follows_d  = 1'b0;
        sending_d  = 1'b1;
        do_start   = 1'b1;
        start_poll = poll_busy_q;
      end else begin
        phase_d = PH_IDLE;
      end
    end

    // power-up sequence step
    if (do_init) begin
      case (step_d)
        4'd0, 4'd2, 4'd4: begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end
        4'd1, 4'd3, 4'd5, 4'd6: begin
          pcmd_d     = CMD_FUNC_SET;
          sending_d  = 1'b0;
          do_start   = 1'b1;
          start_poll = (step_d == 4'd6);
        end
        4'd7, 4'd8, 4'd9, 4'd10: begin
          case (step_d)
            4'd7:    pcmd_d = CMD_DISP_OFF;
            4'd8:    pcmd_d = CMD_CLEAR;
            4'd9:    pcmd_d = CMD_ENTRY;
            default: pcmd_d = CMD_DISP_ON;
          endcase
          sending_d  = 1'b0;
          do_start   = 1'b1;
          start_poll = 1'b1;
        end
        default: begin
          inited_d = 1'b1;
          step_d   = 4'd0;
          phase_d  = PH_IDLE;
        end
      endcase
    end

    // start a write, with or without a busy read
    if (do_start) begin
      if (start_poll) begin
        rs_d    = 1'b0;
        rw_d    = 1'b1;
        en_d    = 1'b1;
        drive_d = 1'b0;
        bus_d   = 8'h00;
        phase_d = PH_BUSY_HI;
        cnt_d   = '0;
      end else begin
        do_setup = 1'b1;
      end
    end

    // drive rs and the byte, enable low
    if (do_setup) begin
      rs_d    = sending_d;
      rw_d    = 1'b0;
      en_d    = 1'b0;
      drive_d = 1'b1;
      bus_d   = sending_d ? pchr_d : pcmd_d;
      phase_d = PH_SETUP;
      cnt_d   = '0;
    end

    res_new.reg_select       = rs_d;
    res_new.read_write       = rw_d;
    res_new.enable_pin       = en_d;
    res_new.bus_value        = drive_d ? bus_d : 8'h00;
    res_new.bus_drive        = drive_d;
    res_new.ready_res        = (phase_d == PH_IDLE) && inited_d;
    res_new.request_rejected = rejected;
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      step_q    <= 4'd0;
      pcmd_q    <= 8'h00;
      pchr_q    <= 8'h00;
      follows_q <= 1'b0;
      inited_q  <= 1'b0;
      sending_q <= 1'b0;
      rs_q      <= 1'b0;
      rw_q      <= 1'b0;
      en_q      <= 1'b0;
      drive_q   <= 1'b1;
      bus_q     <= 8'h00;
    end else if (req_fire) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      pcmd_q    <= pcmd_d;
      pchr_q    <= pchr_d;
      follows_q <= follows_d;
      inited_q  <= inited_d;
      sending_q <= sending_d;
      rs_q      <= rs_d;
      rw_q      <= rw_d;
      en_q      <= en_d;
      drive_q   <= drive_d;
      bus_q     <= bus_d;
    end
  end

  // two-entry output buffer: result register plus skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (res_fire) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (req_fire) begin
        if (!out_vld_q || res_fire) out_vld_q <= 1'b1;
        else skid_vld_q <= 1'b1;
      end else if (res_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (res_fire) out_q <= skid_q;
    end else if (req_fire) begin
      if (!out_vld_q || res_fire) out_q <= res_new;
      else skid_q <= res_new;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.reg_select       = out_q.reg_select;
  assign res_o.read_write       = out_q.read_write;
  assign res_o.enable_pin       = out_q.enable_pin;
  assign res_o.bus_value        = out_q.bus_value;
  assign res_o.bus_drive        = out_q.bus_drive;
  assign res_o.ready_res        = out_q.ready_res;
  assign res_o.request_rejected = out_q.request_rejected;

endmodule

`default_nettype wire

// ===== hdl/clpc_checker.sv =====
// clpc_checker: port-level assertions for the lcd controller result channel
// plain signal ports, no dependencies; bound to char_lcd_parallel_controller_unit below
`timescale 1ns / 1ps
`default_nettype none

module clpc_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       res_valid_i,
  input  wire logic       res_ready_i,
  input  wire logic       reg_select_i,
  input  wire logic       read_write_i,
  input  wire logic       enable_pin_i,
  input  wire logic [7:0] bus_value_i,
  input  wire logic       bus_drive_i,
  input  wire logic       ready_res_i
);

  // a waiting result stays valid, with its bus value and enable pin held, until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(bus_value_i)
    && $stable(enable_pin_i))
    else $error("result word changed while stalled");

  // bus is released exactly during a busy read
  a_drive_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (bus_drive_i != read_write_i))
    else $error("bus drive and read/write disagree");

  // a released bus reads as zero and busy reads use the command register
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && read_write_i |-> bus_value_i == 8'h00 && !reg_select_i)
    else $error("busy read with rs set or bus value");

  // an idle initialised display has enable low and the bus driven for writing
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && ready_res_i |-> !enable_pin_i && bus_drive_i && !read_write_i)
    else $error("idle with active pins");

endmodule

bind char_lcd_parallel_controller_unit clpc_checker u_clpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .reg_select_i (res_o.reg_select),
  .read_write_i (res_o.read_write),
  .enable_pin_i (res_o.enable_pin),
  .bus_value_i  (res_o.bus_value),
  .bus_drive_i  (res_o.bus_drive),
  .ready_res_i  (res_o.ready_res)
);

`default_nettype wire

// ===== tb/sv/char_lcd_parallel_controller_unit_tb.sv =====
// char_lcd_parallel_controller_unit_tb: self-checking bench for the lcd bus sequencer
// a pin-level predictor follows every accepted word; needs clpc_pkg, clpc_if and the top level
`timescale 1ns / 1ps

module char_lcd_parallel_controller_unit_tb;
  import clpc_pkg::*;

  localparam int IDLE_PCT       = 25;
  localparam int QUIET_FROM     = 10000;
  localparam int QUIET_TO       = 16000;
  localparam int HOLDOFF_AT     = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_WORDS   = 1400;
  localparam int RECONFIG_EVERY = 200;

  // commands sent with busy polling at the tail of the power-up sequence
  localparam logic [7:0] POLLED_INIT_CMD [7:10] = '{CMD_DISP_OFF, CMD_CLEAR, CMD_ENTRY,
                                                    CMD_DISP_ON};

  typedef struct packed {
    opcode_e    op;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] chr;
    logic       busy;
  } lcd_req_t;

  typedef struct packed {
    logic              poll;
    logic [TIME_W-1:0] setup;
    logic [TIME_W-1:0] pulse;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] sample;
  } lcd_timing_t;

  typedef struct packed {
    phase_e           phase;
    logic [CNT_W-1:0] us_cnt;
    logic [3:0]       step;
    logic [7:0]       cmd;
    logic [7:0]       chr;
    logic             data_next;
    logic             inited;
    logic             send_data;
    logic             rs;
    logic             rw;
    logic             en;
    logic [7:0]       bus;
    logic             drive;
  } lcd_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_we   = 1'b0;
  cfg_idx_e          cfg_idx  = CFG_POLL_BUSY;
  logic [TIME_W-1:0] cfg_data = '0;

  logic     word_valid = 1'b0;
  lcd_req_t word_out   = '0;
  logic     pins_ready = 1'b0;
  logic     req_took   = 1'b0;

  int cycle_cnt    = 0;
  int fail_cnt     = 0;
  int stall_left   = 0;
  int busy_pct     = 30;
  int random_words = 0;
  int next_cfg_at  = 0;

  lcd_timing_t lcd_timing;
  lcd_state_t  plan_st;
  lcd_state_t  pred_st;
  lcd_req_t    lcd_word_q[$];
  res_t        expected_pins_q[$];

  wire quiet_stretch = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  clpc_req_if req_if ();
  clpc_res_if res_if ();

  assign req_if.valid     = word_valid;
  assign req_if.opcode    = word_out.op;
  assign req_if.row       = word_out.row;
  assign req_if.column    = word_out.col;
  assign req_if.character = word_out.chr;
  assign req_if.busy_line = word_out.busy;
  assign res_if.ready     = pins_ready;

  char_lcd_parallel_controller_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // drive rs and the byte with en low
  function automatic void drive_write_setup(inout lcd_state_t s);
    s.rs     = s.send_data;
    s.rw     = 1'b0;
    s.en     = 1'b0;
    s.drive  = 1'b1;
    s.bus    = s.send_data ? s.chr : s.cmd;
    s.phase  = PH_SETUP;
    s.us_cnt = '0;
  endfunction

  // either a busy read first or straight into setup
  function automatic void begin_bus_write(inout lcd_state_t s, input logic poll);
    if (poll) begin
      s.rs     = 1'b0;
      s.rw     = 1'b1;
      s.en     = 1'b1;
      s.drive  = 1'b0;
      s.bus    = '0;
      s.phase  = PH_BUSY_HI;
      s.us_cnt = '0;
    end else begin
      drive_write_setup(s);
    end
  endfunction

  // power-up: waits, three blind function sets, then polled commands
  function automatic void next_power_up_step(inout lcd_state_t s);
    case (s.step)
      4'd0, 4'd2, 4'd4: begin
        s.phase  = PH_WAIT;
        s.us_cnt = '0;
      end
      4'd1, 4'd3, 4'd5, 4'd6: begin
        s.cmd       = CMD_FUNC_SET;
        s.send_data = 1'b0;
        begin_bus_write(s, s.step == 4'd6);
      end
      4'd7, 4'd8, 4'd9, 4'd10: begin
        s.cmd       = POLLED_INIT_CMD[s.step];
        s.send_data = 1'b0;
        begin_bus_write(s, 1'b1);
      end
      default: begin
        s.inited = 1'b1;
        s.step   = '0;
        s.phase  = PH_IDLE;
      end
    endcase
  endfunction

  // end of an access: next init step, the data write, or back to idle
  function automatic void finish_access(inout lcd_state_t s, input lcd_timing_t t);
    if (!s.inited) begin
      s.step = s.step + 4'd1;
      next_power_up_step(s);
    end else if (s.data_next) begin
      s.data_next = 1'b0;
      s.send_data = 1'b1;
      begin_bus_write(s, t.poll);
    end else begin
      s.phase = PH_IDLE;
    end
  endfunction

  // one word in, the pin levels after it out
  function automatic res_t next_pins(inout lcd_state_t s, input lcd_timing_t t,
                                     input lcd_req_t w);
    res_t       r;
    int         elapsed;
    logic [7:0] base;
    r = '0;
    if (w.op == OP_TICK) begin
      s.us_cnt = s.us_cnt + CNT_W'(1);
      elapsed  = int'(s.us_cnt);
      case (s.phase)
        PH_WAIT: begin
          if (elapsed >= ((s.step == 4'd0) ? int'(POWERUP_WAIT_US) : int'(RETRY_WAIT_US)))
            finish_access(s, t);
        end
        PH_BUSY_HI: begin
          if (elapsed >= int'(t.sample)) begin
            s.en = 1'b0;
            if (w.busy) s.phase = PH_BUSY_LO;
            else drive_write_setup(s);
          end
        end
        PH_BUSY_LO: begin
          s.en     = 1'b1;
          s.phase  = PH_BUSY_HI;
          s.us_cnt = '0;
        end
        PH_SETUP: begin
          if (elapsed >= int'(t.setup)) begin
            s.en     = 1'b1;
            s.phase  = PH_PULSE;
            s.us_cnt = '0;
          end
        end
        PH_PULSE: begin
          if (elapsed >= int'(t.pulse)) begin
            s.en     = 1'b0;
            s.phase  = PH_HOLD;
            s.us_cnt = '0;
          end
        end
        PH_HOLD: begin
          if (elapsed >= int'(t.hold)) finish_access(s, t);
        end
        default: s.us_cnt = '0;
      endcase
    end else if (s.phase != PH_IDLE) begin
      r.request_rejected = 1'b1;
    end else if (w.op == OP_INIT) begin
      s.inited    = 1'b0;
      s.data_next = 1'b0;
      s.send_data = 1'b0;
      s.step      = '0;
      s.rs        = 1'b0;
      s.rw        = 1'b0;
      s.en        = 1'b0;
      s.bus       = '0;
      s.drive     = 1'b1;
      next_power_up_step(s);
    end else if (!s.inited || w.row > 2'd1 || int'(w.col) >= int'(LINE_COLUMNS)) begin
      r.request_rejected = 1'b1;
    end else begin
      base        = (w.row == 2'd0) ? CMD_ROW0_ADDR : CMD_ROW1_ADDR;
      s.cmd       = base + {3'b000, w.col};
      s.chr       = w.chr;
      s.data_next = (w.op == OP_WRITE_CHR);
      s.send_data = 1'b0;
      begin_bus_write(s, t.poll);
    end
    r.reg_select = s.rs;
    r.read_write = s.rw;
    r.enable_pin = s.en;
    r.bus_value  = s.drive ? s.bus : 8'h00;
    r.bus_drive  = s.drive;
    r.ready_res  = (s.phase == PH_IDLE) && s.inited;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // queue one word and keep the planning copy in step
  task automatic send_word(input opcode_e op, input logic [1:0] row, input logic [4:0] col,
                           input logic [7:0] chr);
    lcd_req_t w;
    w.op   = op;
    w.row  = row;
    w.col  = col;
    w.chr  = chr;
    w.busy = ($urandom_range(99) < busy_pct);
    if (!(op == OP_TICK && plan_st.phase == PH_IDLE)) random_words++;
    void'(next_pins(plan_st, lcd_timing, w));
    lcd_word_q.push_back(w);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 2'($urandom), 5'($urandom), 8'($urandom));
  endtask

  // tick until the sequencer is idle, with stray requests while it works
  task automatic run_until_idle(input int stray_pct);
    while (plan_st.phase != PH_IDLE) begin
      if ($urandom_range(99) < stray_pct)
        send_word(opcode_e'($urandom_range(3, 1)), 2'($urandom), 5'($urandom), 8'($urandom));
      else
        send_tick();
    end
  endtask

  // hold off until every queued word is taken and every result seen
  task automatic wait_drained();
    do @(posedge clk_i);
    while (lcd_word_q.size() != 0 || word_valid || expected_pins_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TIME_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic apply_timing(input lcd_timing_t t);
    write_reg(CFG_POLL_BUSY, {{(TIME_W-1){1'b0}}, t.poll});
    write_reg(CFG_SETUP, t.setup);
    write_reg(CFG_PULSE, t.pulse);
    write_reg(CFG_HOLD, t.hold);
    write_reg(CFG_SAMPLE, t.sample);
    lcd_timing = t;
    @(posedge clk_i);
  endtask

  // mostly short durations so that sequences finish quickly
  function automatic logic [TIME_W-1:0] pick_duration(input int lo);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return TIME_W'($urandom_range(8, lo));
    if (pick < 95) return TIME_W'($urandom_range(40, lo));
    return TIME_W'($urandom_range(150, 100));
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------- driver

  // request side, changes on the falling edge
  always @(negedge clk_i) begin : drive_words
    if (!rst_ni) begin
      word_valid <= 1'b0;
    end else if (!word_valid || req_took) begin
      if (lcd_word_q.size() != 0 && (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
        word_out   <= lcd_word_q.pop_front();
        word_valid <= 1'b1;
      end else begin
        word_valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pins_ready <= 1'b0;
    end else begin
      if (cycle_cnt == HOLDOFF_AT) stall_left = HOLDOFF_CYCLES;
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        pins_ready <= 1'b0;
      end else begin
        pins_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch_pins
    res_t got;
    res_t want;
    if (!rst_ni) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_if.valid && req_if.ready;
      // result word against the oldest prediction
      if (res_if.valid && res_if.ready) begin
        got.reg_select       = res_if.reg_select;
        got.read_write       = res_if.read_write;
        got.enable_pin       = res_if.enable_pin;
        got.bus_value        = res_if.bus_value;
        got.bus_drive        = res_if.bus_drive;
        got.ready_res        = res_if.ready_res;
        got.request_rejected = res_if.request_rejected;
        if (expected_pins_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          want = expected_pins_q.pop_front();
          check_field("reg_select", 8'(want.reg_select), 8'(got.reg_select));
          check_field("read_write", 8'(want.read_write), 8'(got.read_write));
          check_field("enable_pin", 8'(want.enable_pin), 8'(got.enable_pin));
          check_field("bus_value", want.bus_value, got.bus_value);
          check_field("bus_drive", 8'(want.bus_drive), 8'(got.bus_drive));
          check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
          check_field("request_rejected", 8'(want.request_rejected),
                      8'(got.request_rejected));
        end
      end
      // accepted request word moves the predictor
      if (req_if.valid && req_if.ready)
        expected_pins_q.push_back(next_pins(pred_st, lcd_timing, word_out));
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("char_lcd_parallel_controller_unit_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    lcd_timing = '{poll: 1'b0, setup: SETUP_RST, pulse: PULSE_RST, hold: HOLD_RST,
                   sample: SAMPLE_RST};
    plan_st       = '0;
    plan_st.phase = PH_IDLE;
    plan_st.drive = 1'b1;
    pred_st       = plan_st;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before power-up: ticks do nothing, user requests are turned away
    send_tick();
    send_tick();
    send_word(OP_WRITE_CHR, 2'd0, 5'd0, 8'hFF);
    send_word(OP_SET_CUR, 2'd1, 5'd15, 8'h00);
    send_word(OP_WRITE_CHR, 2'd3, 5'd31, 8'h00);

    // power-up at the default timing, stray requests while it runs
    send_word(OP_INIT, 2'd3, 5'd31, 8'hFF);
    run_until_idle(2);
    wait_drained();

    // shortest timing, fixed delays
    apply_timing('{poll: 1'b0, setup: '0, pulse: TIME_W'(1), hold: '0, sample: TIME_W'(1)});
    send_word(OP_WRITE_CHR, 2'd0, 5'd0, 8'h00);
    run_until_idle(0);
    send_word(OP_WRITE_CHR, 2'd1, 5'd15, 8'hFF);
    run_until_idle(20);
    send_word(OP_SET_CUR, 2'd1, 5'd7, 8'h3C);
    run_until_idle(20);
    // out of range row or column
    send_word(OP_WRITE_CHR, 2'd2, 5'd0, 8'h11);
    send_word(OP_SET_CUR, 2'd3, 5'd5, 8'h22);
    send_word(OP_WRITE_CHR, 2'd0, 5'd16, 8'h33);
    send_word(OP_SET_CUR, 2'd1, 5'd31, 8'h44);
    wait_drained();

    // shortest timing with busy polling and a busy display
    apply_timing('{poll: 1'b1, setup: '0, pulse: TIME_W'(1), hold: '0, sample: TIME_W'(1)});
    busy_pct = 50;
    send_word(OP_WRITE_CHR, 2'd0, 5'd9, 8'hA5);
    run_until_idle(10);
    wait_drained();

    // longest timing everywhere
    apply_timing('{poll: 1'b1, setup: '1, pulse: '1, hold: '1, sample: '1});
    busy_pct = 5;
    send_word(OP_WRITE_CHR, 2'd1, 5'd3, 8'h5A);
    run_until_idle(1);
    send_word(OP_SET_CUR, 2'd0, 5'd12, 8'h00);
    run_until_idle(1);

    // random traffic, mostly well-formed requests under changing timing
    random_words = 0;
    next_cfg_at  = 0;
    while (random_words < RANDOM_WORDS) begin : random_traffic
      int pick;
      if (random_words >= next_cfg_at) begin
        wait_drained();
        apply_timing('{poll: 1'($urandom_range(1)), setup: pick_duration(0),
                       pulse: pick_duration(1), hold: pick_duration(0),
                       sample: pick_duration(1)});
        busy_pct    = $urandom_range(40);
        next_cfg_at = next_cfg_at + RECONFIG_EVERY;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_word((pick < 40) ? OP_WRITE_CHR : OP_SET_CUR, 2'($urandom_range(1)),
                  5'($urandom_range(15)), 8'($urandom));
        run_until_idle(8);
      end else if (pick < 90) begin : bad_position
        logic [1:0] row;
        logic [4:0] col;
        row = 2'($urandom);
        col = 5'($urandom);
        if (row <= 2'd1 && col < 5'd16) col = col + 5'd16;
        send_word((pick < 80) ? OP_WRITE_CHR : OP_SET_CUR, row, col, 8'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_tick();
      end
    end

    // restart the power-up once initialised, then a few writes
    wait_drained();
    apply_timing('{poll: 1'($urandom_range(1)), setup: pick_duration(0),
                   pulse: pick_duration(1), hold: pick_duration(0), sample: pick_duration(1)});
    busy_pct = 20;
    send_word(OP_INIT, 2'($urandom), 5'($urandom), 8'($urandom));
    run_until_idle(3);
    repeat (6) begin
      send_word(opcode_e'($urandom_range(2, 1)), 2'($urandom_range(1)),
                5'($urandom_range(15)), 8'($urandom));
      run_until_idle(5);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("char_lcd_parallel_controller_unit_tb: clean");
    else
      $display("char_lcd_parallel_controller_unit_tb: errors");
    $finish;
  end

endmodule
